/* rtl/lpfp_pkg.sv */
// Shared types and constants for the length-prefixed frame parser.
package lpfp_pkg;

    // Frame length limits
    localparam logic [31:0] MIN_BODY_LENGTH  = 32'd5;
    localparam logic [31:0] DEFAULT_MAX_BODY = 32'd16777216;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  message_type;
        logic [31:0] channel_id;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } result_t;

endpackage

/* rtl/lpfp_parse.sv */
// Frame parser state machine: consumes one byte per step, makes at most one result.
module lpfp_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           max_body_length,
    output logic                  res_valid,
    output lpfp_pkg::result_t     res
);
    import lpfp_pkg::*;

    localparam logic [3:0] POS_LEN_LAST = 4'd3;
    localparam logic [3:0] POS_TYPE     = 4'd4;
    localparam logic [3:0] POS_LAST     = 4'd8;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_pos_reg, hdr_pos_next;
    logic [31:0] len_acc_reg, len_acc_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [31:0] frame_chan_reg, frame_chan_next;
    logic [31:0] remaining_reg, remaining_next;

    logic [31:0] len_shift;
    logic [31:0] rem_dec;
    logic [31:0] plen;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_pos_reg    <= '0;
            len_acc_reg    <= '0;
            frame_type_reg <= '0;
            frame_chan_reg <= '0;
            remaining_reg  <= '0;
        end else begin
            phase_reg      <= phase_next;
            hdr_pos_reg    <= hdr_pos_next;
            len_acc_reg    <= len_acc_next;
            frame_type_reg <= frame_type_next;
            frame_chan_reg <= frame_chan_next;
            remaining_reg  <= remaining_next;
        end
    end

    assign len_shift = {len_acc_reg[23:0], data_byte};
    assign rem_dec   = remaining_reg - 32'd1;
    assign plen      = len_acc_reg - MIN_BODY_LENGTH;

    // Next state and result
    always_comb begin
        phase_next      = phase_reg;
        hdr_pos_next    = hdr_pos_reg;
        len_acc_next    = len_acc_reg;
        frame_type_next = frame_type_reg;
        frame_chan_next = frame_chan_reg;
        remaining_next  = remaining_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (step) begin
            case (phase_reg)
                PH_PAYLOAD: begin
                    remaining_next     = rem_dec;
                    res_valid          = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.message_type   = frame_type_reg;
                    res.channel_id     = frame_chan_reg;
                    res.payload_byte   = data_byte;
                    res.last_of_frame  = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    hdr_pos_next = hdr_pos_reg + 4'd1;
                    if (hdr_pos_reg inside {[4'd0:POS_LEN_LAST]}) begin
                        // length bytes, checked when the fourth arrives
                        len_acc_next = len_shift;
                        if (hdr_pos_reg == POS_LEN_LAST &&
                            (len_shift < MIN_BODY_LENGTH || len_shift > max_body_length)) begin
                            phase_next        = PH_ERROR;
                            res_valid         = 1'b1;
                            res.kind          = KIND_ERROR;
                            res.last_of_frame = 1'b1;
                        end
                    end else if (hdr_pos_reg == POS_TYPE) begin
                        frame_type_next = data_byte;
                    end else begin
                        // channel bytes; header result on the last one
                        frame_chan_next = {frame_chan_reg[23:0], data_byte};
                        if (hdr_pos_reg == POS_LAST) begin
                            res_valid          = 1'b1;
                            res.kind           = KIND_HEADER;
                            res.message_type   = frame_type_reg;
                            res.channel_id     = {frame_chan_reg[23:0], data_byte};
                            res.payload_length = plen;
                            res.last_of_frame  = (plen == '0);
                            hdr_pos_next       = '0;
                            len_acc_next       = '0;
                            remaining_next     = plen;
                            phase_next         = (plen == '0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    // error phase: drop bytes until reset
                end
            endcase
        end
    end

endmodule

/* rtl/length_prefixed_frame_parser.sv */
// Top level of the length-prefixed frame parser.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_data_byte
//  m_        out        m_valid / m_ready   m_result_kind, m_message_type, m_channel_id,
//                                           m_payload_length, m_payload_byte,
//                                           m_last_of_frame
//  cfg_      in         cfg_we              cfg_wdata (max body length)
//
// One byte per clock sustained while the result side does not stall; a byte lands in the
// input register when it is accepted, and its result, if it makes one, lands in the result
// register when the byte moves on into the parser.
// Reset is synchronous, active low; max body length returns to 16 MiB.
// A stalled result holds the result register; the input register still takes a byte
// while the result register is being emptied in the same cycle.
module length_prefixed_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_message_type,
    output logic [31:0] m_channel_id,
    output logic [31:0] m_payload_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_of_frame
);
    import lpfp_pkg::*;

    logic [31:0] max_len_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= DEFAULT_MAX_BODY;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Input register moves into the parser when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    lpfp_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .data_byte       (in_byte_reg),
        .max_body_length (max_len_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = out_res_reg.kind;
    assign m_message_type   = out_res_reg.message_type;
    assign m_channel_id     = out_res_reg.channel_id;
    assign m_payload_length = out_res_reg.payload_length;
    assign m_payload_byte   = out_res_reg.payload_byte;
    assign m_last_of_frame  = out_res_reg.last_of_frame;

endmodule

/* rtl/lpfp_checker.sv */
// Port-level checks for the length-prefixed frame parser, bound to the top level.
module lpfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_result_kind,
    input logic [7:0]  m_message_type,
    input logic [31:0] m_channel_id,
    input logic [31:0] m_payload_length,
    input logic [7:0]  m_payload_byte,
    input logic        m_last_of_frame
);
    import lpfp_pkg::*;

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_channel_id) && $stable(m_payload_byte))
        else $error("stalled result changed");

    // Error result is a bare, final item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_ERROR |-> m_last_of_frame
            && m_message_type == 8'd0 && m_channel_id == 32'd0
            && m_payload_length == 32'd0 && m_payload_byte == 8'd0)
        else $error("malformed error item");

    // Nothing follows a taken error item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_result_kind == KIND_ERROR |=> !m_valid)
        else $error("item after length error");

    // Header closes the frame exactly when the payload is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_HEADER |->
            m_last_of_frame == (m_payload_length == 32'd0))
        else $error("header last flag mismatch");

    // Payload items carry no length and a valid kind code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_kind != 2'd3
            && (m_result_kind != KIND_PAYLOAD || m_payload_length == 32'd0))
        else $error("bad payload item");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_kind    (m_result_kind),
    .m_message_type   (m_message_type),
    .m_channel_id     (m_channel_id),
    .m_payload_length (m_payload_length),
    .m_payload_byte   (m_payload_byte),
    .m_last_of_frame  (m_last_of_frame)
);

/* dv/tb_length_prefixed_frame_parser.sv */
// Self-checking testbench for the length-prefixed frame parser: byte streams in, results checked.
module tb_length_prefixed_frame_parser;
    import lpfp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_message_type;
    logic [31:0] m_channel_id;
    logic [31:0] m_payload_length;
    logic [7:0]  m_payload_byte;
    logic        m_last_of_frame;

    // Shared by both drivers: no idle cycles while set
    bit no_gaps;
    int bytes_sent;

    length_prefixed_frame_parser DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_message_type   (m_message_type),
        .m_channel_id     (m_channel_id),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_frame  (m_last_of_frame)
    );

    // Deframer scoreboard: tracks parse state per accepted byte, holds expected results
    class deframer_sb;
        logic [31:0] max_body;
        phase_t      phase;
        logic [3:0]  hdr_pos;
        logic [31:0] len_acc;
        logic [7:0]  frame_type;
        logic [31:0] frame_chan;
        logic [31:0] remaining;
        result_t     pending_results[$];
        int          mismatches;

        function new();
            max_body   = DEFAULT_MAX_BODY;
            phase      = PH_HEADER;
            hdr_pos    = '0;
            len_acc    = '0;
            frame_type = '0;
            frame_chan = '0;
            remaining  = '0;
            mismatches = 0;
        endfunction

        task report(input string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        // Advance the parse state by one byte; queue the result it causes, if any
        function void take_byte(input logic [7:0] b);
            result_t r;
            r = '0;
            case (phase)
                PH_PAYLOAD: begin
                    remaining        = remaining - 1;
                    r.kind           = KIND_PAYLOAD;
                    r.message_type   = frame_type;
                    r.channel_id     = frame_chan;
                    r.payload_byte   = b;
                    r.last_of_frame  = (remaining == 0);
                    pending_results.push_back(r);
                    if (remaining == 0) phase = PH_HEADER;
                end
                PH_HEADER: begin
                    if (hdr_pos < 4) begin
                        len_acc = {len_acc[23:0], b};
                        hdr_pos++;
                        // length check once the fourth length byte is in
                        if (hdr_pos == 4 &&
                            (len_acc < MIN_BODY_LENGTH || len_acc > max_body)) begin
                            phase           = PH_ERROR;
                            r.kind          = KIND_ERROR;
                            r.last_of_frame = 1'b1;
                            pending_results.push_back(r);
                        end
                    end else if (hdr_pos == 4) begin
                        frame_type = b;
                        hdr_pos++;
                    end else begin
                        frame_chan = {frame_chan[23:0], b};
                        hdr_pos++;
                        if (hdr_pos == 9) begin
                            r.kind           = KIND_HEADER;
                            r.message_type   = frame_type;
                            r.channel_id     = frame_chan;
                            r.payload_length = len_acc - MIN_BODY_LENGTH;
                            r.last_of_frame  = (r.payload_length == 0);
                            pending_results.push_back(r);
                            hdr_pos   = '0;
                            len_acc   = '0;
                            remaining = r.payload_length;
                            phase     = (r.payload_length == 0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                end
                default: ;  // error phase drops everything
            endcase
        endfunction

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        task match_result(input logic [1:0] kind, input logic [7:0] mtype,
                          input logic [31:0] chan, input logic [31:0] plen,
                          input logic [7:0] pbyte, input logic lof);
            result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result, kind %0d", kind));
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", kind, want.kind);
            compare_field("message_type", mtype, want.message_type);
            compare_field("channel_id", chan, want.channel_id);
            compare_field("payload_length", plen, want.payload_length);
            compare_field("payload_byte", pbyte, want.payload_byte);
            compare_field("last_of_frame", lof, want.last_of_frame);
        endtask
    endclass

    deframer_sb sb;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.take_byte(s_data_byte);
            if (m_valid && m_ready)
                sb.match_result(m_result_kind, m_message_type, m_channel_id,
                                m_payload_length, m_payload_byte, m_last_of_frame);
        end
    end

    // Result side: random stall before each item
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Offer one byte after a random gap; returns on the falling edge after acceptance
    task send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Input goes idle until every expected result has come
    task wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending_results.size() != 0);
    endtask

    // Drain results, then cover the pipeline latency so the parser is truly idle
    task settle();
        wait_drained();
        repeat (8) @(negedge aclk);
    endtask

    task write_max_body(input logic [31:0] v);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        sb.max_body = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Full legal frame; fill < 0 gives random payload; pause_at >= 0 drains before that byte
    task send_frame(input logic [31:0] blen, input logic [7:0] mtype, input logic [31:0] chan,
                    input int fill, input int pause_at);
        logic [7:0]  hdr [9];
        logic [31:0] plen;
        int          idx;
        hdr[0] = blen[31:24];
        hdr[1] = blen[23:16];
        hdr[2] = blen[15:8];
        hdr[3] = blen[7:0];
        hdr[4] = mtype;
        hdr[5] = chan[31:24];
        hdr[6] = chan[23:16];
        hdr[7] = chan[15:8];
        hdr[8] = chan[7:0];
        plen   = blen - MIN_BODY_LENGTH;
        idx    = 0;
        for (int i = 0; i < 9; i++) begin
            if (idx == pause_at) wait_drained();
            send_byte(hdr[i]);
            idx++;
        end
        for (logic [31:0] j = 0; j < plen; j++) begin
            if (idx == pause_at) wait_drained();
            send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
            idx++;
        end
    endtask

    // Random legal frames until about target bytes have gone out
    task run_random(input int target, input logic [31:0] max_len);
        int          stop_at;
        int          r;
        logic [31:0] plen;
        logic [31:0] blen;
        int          pause_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 88)      plen = $urandom_range(0, 12);
            else if (r < 97) plen = $urandom_range(13, 60);
            else             plen = $urandom_range(100, 300);
            blen = MIN_BODY_LENGTH + plen;
            if (blen > max_len) blen = max_len;
            // hit the limit exactly now and then
            if (max_len <= 305 && $urandom_range(0, 9) == 0) blen = max_len;
            pause_at = ($urandom_range(0, 29) == 0) ?
                       $urandom_range(0, 8 + blen - MIN_BODY_LENGTH) : -1;
            no_gaps = ($urandom_range(0, 5) == 0);
            send_frame(blen, 8'($urandom), $urandom, -1, pause_at);
        end
        no_gaps = 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [31:0] limit;
        logic [31:0] bad_len;
        sb          = new();
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        no_gaps     = 1'b0;
        bytes_sent  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty frame with all-ones type and channel, short frames with all-zero and mixed fields
        send_frame(MIN_BODY_LENGTH, 8'hFF, 32'hFFFF_FFFF, -1, -1);
        send_frame(32'd6, 8'h00, 32'h0000_0000, 8'h00, -1);
        send_frame(32'd6, 8'h5A, 32'h0123_4567, 8'hFF, -1);

        // Reset limit
        run_random(500, DEFAULT_MAX_BODY);

        // Smallest limit: only empty frames pass
        settle();
        write_max_body(MIN_BODY_LENGTH);
        run_random(150, MIN_BODY_LENGTH);

        // Largest limit
        settle();
        write_max_body(32'hFFFF_FFFF);
        run_random(500, 32'hFFFF_FFFF);

        // Small random limit, frames at the limit included
        settle();
        limit = $urandom_range(6, 60);
        write_max_body(limit);
        send_frame(limit, 8'($urandom), $urandom, -1, -1);
        run_random(600, limit);

        // Length error is sticky, so it closes the run: too short or too long
        case ($urandom_range(0, 3))
            0:       bad_len = 32'd0;
            1:       bad_len = MIN_BODY_LENGTH - 1;
            2:       bad_len = limit + 1;
            default: bad_len = 32'hFFFF_FFFF;
        endcase
        for (int i = 3; i >= 0; i--) send_byte(bad_len[8*i +: 8]);
        // everything after the error is dropped
        repeat (40) send_byte(8'($urandom));

        wait_drained();
        repeat (10) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lpfp_pkg.sv
rtl/lpfp_parse.sv
rtl/length_prefixed_frame_parser.sv
rtl/lpfp_checker.sv
dv/tb_length_prefixed_frame_parser.sv
